// File: hw/rtl/cia402_drive_enable_sequencer_macros.svh
// assertion macros for the drive enable sequencer checker
// depends on nothing; included by the checker file
`ifndef CIA402_DRIVE_ENABLE_SEQUENCER_MACROS_SVH
`define CIA402_DRIVE_ENABLE_SEQUENCER_MACROS_SVH

// property holds at every clock edge outside reset
`define CIA_DES_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sequencer check failed");

// consequent must hold in the cycle after the antecedent
`define CIA_DES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

// File: hw/rtl/cia_des_pkg.sv
// types and constants for the drive enable sequencer
// no dependencies; imported by every module of the block
package cia_des_pkg;

   typedef struct packed {
      logic [15:0]       drv_status;
      logic signed [7:0] shown_mode;
      logic [15:0]       drv_error;
      logic              link_up;
      logic              data_fresh;
      logic              wkc_ok;
      logic              want_fault_reset;
      logic              want_quick_stop;
      logic              want_enable;
   } cia_des_req_type;

   typedef struct packed {
      logic [15:0] ctrl_cmd;
      logic [3:0]  drive_state;
      logic        mode_ok;
      logic        fault_seen;
      logic        healthy;
      logic        retries_spent;
      logic        motion_ok;
      logic [7:0]  attempts_used;
   } cia_des_rsp_type;

   typedef struct packed {
      logic signed [7:0] target_mode;
      logic [7:0]        max_reset_attempts;
      logic [15:0]       reset_backoff_cycles;
   } cia_des_cfg_type;

   typedef struct packed {
      logic [7:0]  attempt_count;
      logic [15:0] backoff_left;
      logic        exhausted_latch;
   } cia_des_state_type;

   typedef enum logic [1:0] {
      CSR_TARGET_MODE        = 2'd0,
      CSR_MAX_RESET_ATTEMPTS = 2'd1,
      CSR_RESET_BACKOFF      = 2'd2
   } cia_des_csr_index_type;

   localparam logic signed [7:0] TARGET_MODE_RST  = 8'sd0;
   localparam logic [7:0]        MAX_ATTEMPTS_RST = 8'd3;
   localparam logic [15:0]       BACKOFF_RST      = 16'd100;

   // status word decode
   localparam logic [15:0] STATUS_MASK       = 16'h006F;
   localparam logic [15:0] SW_NOT_READY      = 16'h0000;
   localparam logic [15:0] SW_NOT_READY_B5   = 16'h0020;
   localparam logic [15:0] SW_SOD            = 16'h0040;
   localparam logic [15:0] SW_SOD_B5         = 16'h0060;
   localparam logic [15:0] SW_READY          = 16'h0021;
   localparam logic [15:0] SW_SWITCHED_ON    = 16'h0023;
   localparam logic [15:0] SW_OP_ENABLED     = 16'h0027;
   localparam logic [15:0] SW_QSTOP          = 16'h0007;
   localparam logic [15:0] SW_FAULT_REACT    = 16'h000F;
   localparam logic [15:0] SW_FAULT_REACT_B5 = 16'h002F;
   localparam logic [15:0] SW_FAULT          = 16'h0008;
   localparam logic [15:0] SW_FAULT_B5       = 16'h0028;

   // decoded drive states
   localparam logic [3:0] ST_NOT_READY   = 4'd0;
   localparam logic [3:0] ST_SOD         = 4'd1;
   localparam logic [3:0] ST_READY       = 4'd2;
   localparam logic [3:0] ST_SWITCHED_ON = 4'd3;
   localparam logic [3:0] ST_OP_ENABLED  = 4'd4;
   localparam logic [3:0] ST_QSTOP       = 4'd5;
   localparam logic [3:0] ST_FAULT_REACT = 4'd6;
   localparam logic [3:0] ST_FAULT       = 4'd7;
   localparam logic [3:0] ST_UNKNOWN     = 4'd8;

   // control words
   localparam logic [15:0] CW_SHUTDOWN   = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON  = 16'h0007;
   localparam logic [15:0] CW_QUICK_STOP = 16'h000B;
   localparam logic [15:0] CW_ENABLE_OP  = 16'h000F;
   localparam logic [15:0] CW_FAULT_RST  = 16'h0080;

endpackage

// File: hw/rtl/cia_des_step.sv
// one sequencer step: state decode, fault and health judgment, control word
// depends on cia_des_pkg
module cia_des_step
   import cia_des_pkg::*;
(
   input  cia_des_req_type   item,
   input  cia_des_cfg_type   cfg,
   input  cia_des_state_type state,
   output cia_des_rsp_type   result,
   output cia_des_state_type state_next
);

   logic [15:0] masked;
   logic [3:0]  st;
   logic        mode_ok;
   logic        fault;
   logic        health;
   logic        motion;
   logic        active_st;
   logic [15:0] cw;
   cia_des_state_type nxt;

   always_comb begin
      masked = item.drv_status & STATUS_MASK;
      case (masked)
         SW_NOT_READY, SW_NOT_READY_B5:     st = ST_NOT_READY;
         SW_SOD, SW_SOD_B5:                 st = ST_SOD;
         SW_READY:                          st = ST_READY;
         SW_SWITCHED_ON:                    st = ST_SWITCHED_ON;
         SW_OP_ENABLED:                     st = ST_OP_ENABLED;
         SW_QSTOP:                          st = ST_QSTOP;
         SW_FAULT_REACT, SW_FAULT_REACT_B5: st = ST_FAULT_REACT;
         SW_FAULT, SW_FAULT_B5:             st = ST_FAULT;
         default:                           st = ST_UNKNOWN;
      endcase
   end

   assign mode_ok   = (item.shown_mode == cfg.target_mode);
   assign fault     = (st == ST_FAULT) || (item.drv_error != 16'd0);
   assign health    = item.link_up && item.data_fresh && item.wkc_ok && mode_ok && !fault;
   assign active_st = (st == ST_SWITCHED_ON) || (st == ST_OP_ENABLED) || (st == ST_QSTOP);

   always_comb begin
      nxt    = state;
      cw     = CW_SHUTDOWN;
      motion = 1'b0;
      if (!fault) begin
         nxt = '0;
         if (health) begin
            if (item.want_quick_stop) begin
               if (active_st) cw = CW_QUICK_STOP;
            end else if (item.want_enable) begin
               if (st == ST_READY) begin
                  cw = CW_SWITCH_ON;
               end else if (active_st) begin
                  cw = CW_ENABLE_OP;
               end
               motion = (st == ST_OP_ENABLED);
            end
         end
      end else if (state.backoff_left != 16'd0) begin
         nxt.backoff_left = state.backoff_left - 16'd1;
      end else if (item.want_fault_reset && (state.attempt_count < cfg.max_reset_attempts)) begin
         nxt.attempt_count = state.attempt_count + 8'd1;
         nxt.backoff_left  = cfg.reset_backoff_cycles;
         cw                = CW_FAULT_RST;
      end else begin
         nxt.exhausted_latch = 1'b1;
      end
   end

   assign state_next = nxt;

   assign result.ctrl_cmd      = cw;
   assign result.drive_state   = st;
   assign result.mode_ok       = mode_ok;
   assign result.fault_seen    = fault;
   assign result.healthy       = health;
   assign result.retries_spent = nxt.exhausted_latch;
   assign result.motion_ok     = motion;
   assign result.attempts_used = nxt.attempt_count;

endmodule

// File: hw/rtl/cia402_drive_enable_sequencer.sv
// path: input register, then result register; an item leaves the input register
// once the result slot is free; throughput: one item per cycle while results are taken
// the step logic sits between the two registers
// a waiting result still lets one more item into an empty input register
// reset: synchronous active high; clears both valid flags and the attempt, backoff
// and exhaustion state; registers return to mode 0, 3 attempts, backoff of 100
module cia402_drive_enable_sequencer
   import cia_des_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // input items
   input  logic            req_valid,
   output logic            req_ready,
   input  cia_des_req_type req_payload,
   // result items
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output cia_des_rsp_type rsp_payload,
   // register writes
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data
);

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   cia_des_req_type   s1_item_ff;
   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   cia_des_rsp_type   rsp_item_ff;
   // sequencer state and registers
   cia_des_state_type state_ff, state_in;
   cia_des_cfg_type   cfg_ff, cfg_in;

   cia_des_rsp_type   step_result;
   logic              advance;
   logic              csr_write;

   // item moves from input stage to result stage when the result slot is free
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // always writable; the user must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (cia_des_csr_index_type'(csr_index))
            CSR_TARGET_MODE:        cfg_in.target_mode          = csr_data[7:0];
            CSR_MAX_RESET_ATTEMPTS: cfg_in.max_reset_attempts   = csr_data[7:0];
            CSR_RESET_BACKOFF:      cfg_in.reset_backoff_cycles = csr_data;
            default:                cfg_in = cfg_ff; // index beyond the list is ignored
         endcase
      end
   end

   // decode, judge and pick the control word for the item in the input stage
   cia_des_step u_step (
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .result     (step_result),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff       <= '{target_mode: TARGET_MODE_RST,
                           max_reset_attempts: MAX_ATTEMPTS_RST,
                           reset_backoff_cycles: BACKOFF_RST};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         // state commits only when the item's result is captured
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

// File: hw/rtl/cia_des_checker.sv
// port-level checks of the drive enable sequencer, bound to the top level
// depends on cia_des_pkg and the sequencer macro header
`include "cia402_drive_enable_sequencer_macros.svh"

module cia_des_checker
   import cia_des_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input cia_des_rsp_type rsp_payload
);

   logic stalled;
   logic no_fault_out;
   logic motion_out;
   logic healthy_out;
   logic recovery_clear;
   logic motion_legal;
   logic health_legal;

   assign stalled      = rsp_valid && !rsp_ready;
   assign no_fault_out = rsp_valid && !rsp_payload.fault_seen;
   assign motion_out   = rsp_valid && rsp_payload.motion_ok;
   assign healthy_out  = rsp_valid && rsp_payload.healthy;

   assign recovery_clear = (rsp_payload.attempts_used == 8'd0) && !rsp_payload.retries_spent;
   assign motion_legal   = (rsp_payload.ctrl_cmd == CW_ENABLE_OP) &&
                           (rsp_payload.drive_state == ST_OP_ENABLED) && rsp_payload.healthy;
   assign health_legal   = !rsp_payload.fault_seen && rsp_payload.mode_ok;

   // a stalled result holds
   `CIA_DES_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_payload))

   // without a fault the recovery state reads clear
   `CIA_DES_ASSERT(a_no_fault_clear, clock, reset, !no_fault_out || recovery_clear)

   // motion only with enable operation in operation enabled and good health
   `CIA_DES_ASSERT(a_motion_gate, clock, reset, !motion_out || motion_legal)

   // healthy implies no fault and the right mode
   `CIA_DES_ASSERT(a_health_gate, clock, reset, !healthy_out || health_legal)

endmodule

bind cia402_drive_enable_sequencer cia_des_checker u_cia_des_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: tb/cia402_drive_enable_sequencer_checker.sv
// checker for the drive enable sequencer: watches the item, result and register channels,
// predicts each result and compares it field by field
// depends on cia_des_pkg for the payload types and the status/state/control word codes
module cia402_drive_enable_sequencer_checker
   import cia_des_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  cia_des_req_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  cia_des_rsp_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data,
   output int              mismatches,
   output int              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   cia_des_cfg_type   cfg;
   cia_des_state_type seq;
   cia_des_rsp_type   pending_rsp [$];

   function automatic logic [3:0] decode_drive_state(input logic [15:0] sw);
      case (sw & STATUS_MASK)
         SW_NOT_READY, SW_NOT_READY_B5:  return ST_NOT_READY;
         SW_SOD, SW_SOD_B5:              return ST_SOD;
         SW_READY:                       return ST_READY;
         SW_SWITCHED_ON:                 return ST_SWITCHED_ON;
         SW_OP_ENABLED:                  return ST_OP_ENABLED;
         SW_QSTOP:                       return ST_QSTOP;
         SW_FAULT_REACT, SW_FAULT_REACT_B5: return ST_FAULT_REACT;
         SW_FAULT, SW_FAULT_B5:          return ST_FAULT;
         default:                        return ST_UNKNOWN;
      endcase
   endfunction

   // one status sample through the sequencer; advances the recovery state
   function automatic cia_des_rsp_type sequence_step(input cia_des_req_type it);
      cia_des_rsp_type r;
      logic [3:0]      st;
      logic [15:0]     cw;
      logic            mode_ok, fault, health, motion, running;
      st      = decode_drive_state(it.drv_status);
      mode_ok = (it.shown_mode == cfg.target_mode);
      fault   = (st == ST_FAULT) || (it.drv_error != 16'd0);
      health  = it.link_up && it.data_fresh && it.wkc_ok && mode_ok && !fault;
      running = (st == ST_SWITCHED_ON) || (st == ST_OP_ENABLED) || (st == ST_QSTOP);
      cw      = CW_SHUTDOWN;
      motion  = 1'b0;
      if (!fault)
         seq = '0;
      if (fault) begin
         if (seq.backoff_left != 16'd0) begin
            seq.backoff_left = seq.backoff_left - 16'd1;
         end else if (it.want_fault_reset && seq.attempt_count < cfg.max_reset_attempts) begin
            seq.attempt_count = seq.attempt_count + 8'd1;
            seq.backoff_left  = cfg.reset_backoff_cycles;
            cw                = CW_FAULT_RST;
         end else begin
            seq.exhausted_latch = 1'b1;
         end
      end else if (health && it.want_quick_stop) begin
         if (running)
            cw = CW_QUICK_STOP;
      end else if (health && it.want_enable) begin
         if (st == ST_READY)
            cw = CW_SWITCH_ON;
         else if (running)
            cw = CW_ENABLE_OP;
         motion = (st == ST_OP_ENABLED);
      end
      r.ctrl_cmd      = cw;
      r.drive_state   = st;
      r.mode_ok       = mode_ok;
      r.fault_seen    = fault;
      r.healthy       = health;
      r.retries_spent = seq.exhausted_latch;
      r.motion_ok     = motion;
      r.attempts_used = seq.attempt_count;
      return r;
   endfunction

   function automatic int field_diff(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
      if (want === got)
         return 0;
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : monitor
      cia_des_rsp_type want_rsp;
      int              bad;
      int              pushed;
      int              popped;
      bad    = 0;
      pushed = 0;
      popped = 0;
      if (reset) begin
         cfg.target_mode          = TARGET_MODE_RST;
         cfg.max_reset_attempts   = MAX_ATTEMPTS_RST;
         cfg.reset_backoff_cycles = BACKOFF_RST;
         seq                      = '0;
         pending_rsp.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_MODE:        cfg.target_mode          = csr_data[7:0];
               CSR_MAX_RESET_ATTEMPTS: cfg.max_reset_attempts   = csr_data[7:0];
               CSR_RESET_BACKOFF:      cfg.reset_backoff_cycles = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t ns: result with none expected, actual 0x%0h", $time, rsp_payload);
               bad = 1;
            end else begin
               want_rsp = pending_rsp.pop_front();
               popped   = 1;
               bad += field_diff("ctrl_cmd", want_rsp.ctrl_cmd, rsp_payload.ctrl_cmd);
               bad += field_diff("drive_state", 16'(want_rsp.drive_state),
                                 16'(rsp_payload.drive_state));
               bad += field_diff("mode_ok", 16'(want_rsp.mode_ok), 16'(rsp_payload.mode_ok));
               bad += field_diff("fault_seen", 16'(want_rsp.fault_seen),
                                 16'(rsp_payload.fault_seen));
               bad += field_diff("healthy", 16'(want_rsp.healthy), 16'(rsp_payload.healthy));
               bad += field_diff("retries_spent", 16'(want_rsp.retries_spent),
                                 16'(rsp_payload.retries_spent));
               bad += field_diff("motion_ok", 16'(want_rsp.motion_ok),
                                 16'(rsp_payload.motion_ok));
               bad += field_diff("attempts_used", 16'(want_rsp.attempts_used),
                                 16'(rsp_payload.attempts_used));
            end
         end
         if (req_valid && req_ready) begin
            pending_rsp.push_back(sequence_step(req_payload));
            pushed = 1;
         end
         outstanding <= outstanding + pushed - popped;
         mismatches  <= mismatches + bad;
      end
   end

endmodule

// File: tb/tb.sv
// top of the drive enable sequencer testbench: clock, reset, stimulus and verdict
// depends on cia_des_pkg, the sequencer itself and the checker module
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cia_des_pkg::*;

   // cycles with no handshake on any channel before the run is declared hung
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int RANDOM_PER_PHASE = 55;
   localparam int PHASES           = 8;
   // index past the register list, written to check that it is ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // host request flags, packed {link, fresh, wkc, fault reset, quick stop, enable}
   localparam logic [5:0] GOOD_ENABLE  = 6'b111_001;
   localparam logic [5:0] GOOD_QSTOP   = 6'b111_010;
   localparam logic [5:0] GOOD_QS_EN   = 6'b111_011;
   localparam logic [5:0] GOOD_NO_REQ  = 6'b111_000;
   localparam logic [5:0] GOOD_RESET   = 6'b111_101;
   localparam logic [5:0] LINK_DOWN    = 6'b011_001;
   localparam logic [5:0] PDO_STALE    = 6'b101_001;
   localparam logic [5:0] WKC_BAD      = 6'b110_001;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   cia_des_req_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   cia_des_rsp_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [15:0]     csr_data;

   int         mismatches;
   int         outstanding;
   int         sender_idle_pct    = 0;
   int         receiver_stall_pct = 0;
   int         quiet_cycles       = 0;
   logic [7:0] cur_mode;

   always #5ns clock = ~clock;

   cia402_drive_enable_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   cia402_drive_enable_sequencer_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // result side back-pressure, redrawn every cycle at the current stall rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // hang detection: any accepted item, result or register write restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic cia_des_req_type make_item(input logic [15:0] sw, input logic [7:0] mode,
                                                 input logic [15:0] err, input logic [5:0] flags);
      cia_des_req_type it;
      it.drv_status       = sw;
      it.shown_mode       = mode;
      it.drv_error        = err;
      it.link_up          = flags[5];
      it.data_fresh       = flags[4];
      it.wkc_ok           = flags[3];
      it.want_fault_reset = flags[2];
      it.want_quick_stop  = flags[1];
      it.want_enable      = flags[0];
      return it;
   endfunction

   // masked status pattern, weighted toward the states a running drive walks through
   function automatic logic [15:0] pick_pattern();
      case ($urandom_range(0, 15))
         0:          return SW_NOT_READY;
         1:          return SW_NOT_READY_B5;
         2:          return SW_SOD;
         3:          return SW_SOD_B5;
         4, 5:       return SW_READY;
         6, 7:       return SW_SWITCHED_ON;
         8, 9, 10:   return SW_OP_ENABLED;
         11:         return SW_QSTOP;
         12:         return SW_FAULT_REACT;
         13:         return SW_FAULT_REACT_B5;
         14:         return SW_FAULT;
         default:    return 16'($urandom) & STATUS_MASK;
      endcase
   endfunction

   // a plausible sample; inside a fault episode the drive reports a fault one way or both
   function automatic cia_des_req_type random_item(input bit faulted);
      cia_des_req_type it;
      logic [15:0]     noise;
      logic [15:0]     pattern;
      bit              status_fault;
      noise        = 16'($urandom);
      status_fault = faulted && ($urandom_range(1) == 1);
      if (status_fault)
         pattern = ($urandom_range(1) == 1) ? SW_FAULT_B5 : SW_FAULT;
      else
         pattern = pick_pattern();
      it.drv_status = (noise & ~STATUS_MASK) | pattern;
      it.shown_mode = ($urandom_range(99) < 85) ? cur_mode : 8'($urandom);
      if (faulted && (!status_fault || $urandom_range(1) == 1))
         it.drv_error = 16'($urandom_range(1, 65535));
      else if ($urandom_range(99) < 3)
         it.drv_error = 16'($urandom);
      else
         it.drv_error = 16'd0;
      it.link_up          = ($urandom_range(99) < 93);
      it.data_fresh       = ($urandom_range(99) < 93);
      it.wkc_ok           = ($urandom_range(99) < 93);
      it.want_fault_reset = ($urandom_range(99) < (faulted ? 85 : 50));
      it.want_quick_stop  = ($urandom_range(99) < 12);
      it.want_enable      = ($urandom_range(99) < 85);
      return it;
   endfunction

   // valid stays high after the item is taken so back-to-back items never
   // drop it and raise it again within one step
   task automatic send_item(input cia_des_req_type it);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct)
            @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // sender holds off until every outstanding result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // only called with the block idle; upper bits of the byte registers carry noise
   task automatic program_regs(input logic [7:0] mode, input logic [7:0] attempts,
                               input logic [15:0] backoff);
      logic [15:0] noise;
      noise = 16'($urandom);
      write_reg(CSR_UNUSED, noise);
      write_reg(CSR_TARGET_MODE, {noise[15:8], mode});
      write_reg(CSR_MAX_RESET_ATTEMPTS, {~noise[15:8], attempts});
      write_reg(CSR_RESET_BACKOFF, backoff);
      csr_valid <= 1'b0;
      cur_mode = mode;
   endtask

   // healthy traffic broken by fault episodes, with some fully random items mixed in
   task automatic run_random(input int count);
      cia_des_req_type it;
      logic [63:0]     noise;
      int              fault_left;
      fault_left = 0;
      repeat (count) begin
         if (fault_left == 0 && $urandom_range(99) < 8)
            fault_left = $urandom_range(1, 12);
         if ($urandom_range(99) < 10) begin
            noise = {$urandom, $urandom};
            it    = noise[$bits(cia_des_req_type)-1:0];
         end else begin
            it = random_item(fault_left != 0);
         end
         if (fault_left != 0)
            fault_left--;
         send_item(it);
      end
   endtask

   initial begin : stimulus
      logic [7:0]  mode;
      logic [7:0]  attempts;
      logic [15:0] backoff;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      cur_mode    = TARGET_MODE_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed walk with the reset register values: every state decode,
      // bit 5 and the ignored bits, each control word and each health flag
      send_item(make_item(SW_NOT_READY, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_NOT_READY_B5 | 16'hFF90, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_SOD, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_SOD_B5, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_READY | 16'hFF90, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_SWITCHED_ON, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_QSTOP, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0000, GOOD_QS_EN));
      send_item(make_item(SW_QSTOP, 8'h00, 16'h0000, GOOD_QSTOP));
      // quick stop outside the running states falls back to shutdown
      send_item(make_item(SW_READY, 8'h00, 16'h0000, GOOD_QSTOP));
      // enable in fault reaction or an unknown pattern gives shutdown
      send_item(make_item(SW_FAULT_REACT, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_FAULT_REACT_B5, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(16'h0001, 8'h00, 16'h0000, GOOD_ENABLE));
      // unhealthy bus or wrong mode blocks the enable path
      send_item(make_item(SW_OP_ENABLED, 8'h7F, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_OP_ENABLED, 8'h80, 16'h0000, WKC_BAD));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0000, LINK_DOWN));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0000, PDO_STALE));
      send_item(make_item(SW_SWITCHED_ON, 8'h00, 16'h0000, GOOD_NO_REQ));
      // fault reset, a second fault inside the long default backoff, then recovery clears
      send_item(make_item(SW_FAULT, 8'h00, 16'h0000, GOOD_RESET));
      send_item(make_item(SW_FAULT_B5, 8'h00, 16'hFFFF, GOOD_RESET));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0000, GOOD_ENABLE));
      drain_results();

      // zero backoff and two attempts: reset, reset, then the exhaustion latch
      program_regs(8'h00, 8'd2, 16'd0);
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0001, GOOD_RESET));
      send_item(make_item(SW_FAULT, 8'h00, 16'h0000, GOOD_RESET));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h8000, GOOD_RESET));
      send_item(make_item(SW_FAULT, 8'h00, 16'h0000, GOOD_ENABLE));
      send_item(make_item(SW_OP_ENABLED, 8'h00, 16'h0000, GOOD_ENABLE));

      // random phases, each with its own register setting and idle/stall mix
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
            default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         case (phase)
            0: begin
               mode = TARGET_MODE_RST; attempts = MAX_ATTEMPTS_RST; backoff = BACKOFF_RST;
            end
            1: begin mode = 8'h80; attempts = 8'd0;   backoff = 16'd0; end
            2: begin mode = 8'h7F; attempts = 8'd255; backoff = 16'd0; end
            3: begin mode = 8'($urandom); attempts = 8'd2; backoff = 16'd1; end
            4: begin mode = 8'($urandom); attempts = 8'd1; backoff = 16'hFFFF; end
            5: begin
               mode     = 8'($urandom);
               attempts = 8'($urandom_range(1, 6));
               backoff  = 16'($urandom_range(0, 4));
            end
            6: begin mode = 8'h55; attempts = 8'd4; backoff = 16'd3; end
            default: begin
               mode     = 8'($urandom);
               attempts = 8'($urandom);
               backoff  = 16'($urandom_range(0, 2));
            end
         endcase
         program_regs(mode, attempts, backoff);
         run_random(RANDOM_PER_PHASE);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
